FILE: hw/rtl/card_machine_execute_unit_top_assert.svh
// Assertion macros used by the execute unit RTL.
`ifndef CARD_MACHINE_EXECUTE_UNIT_TOP_ASSERT_SVH
`define CARD_MACHINE_EXECUTE_UNIT_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define CMEU_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("execute unit assertion failed");
`define CMEU_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("execute unit assertion failed");
`else
`define CMEU_ASSERT(name, clk, rst, prop)
`define CMEU_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

FILE: hw/rtl/cmeu_pkg.sv
package cmeu_pkg;

   localparam logic [31:0] SPACES    = 32'h2020_2020;
   localparam logic [31:0] END_MARK  = 32'h2445_4E44;
   localparam logic [7:0]  CH_SPACE  = 8'h20;
   localparam logic [7:0]  CH_G      = 8'h47;
   localparam logic [7:0]  CH_D      = 8'h44;
   localparam logic [7:0]  CH_P      = 8'h50;
   localparam logic [7:0]  CH_L      = 8'h4C;
   localparam logic [7:0]  CH_R      = 8'h52;
   localparam logic [7:0]  CH_S      = 8'h53;
   localparam logic [7:0]  CH_C      = 8'h43;
   localparam logic [7:0]  CH_B      = 8'h42;
   localparam logic [7:0]  CH_T      = 8'h54;
   localparam logic [7:0]  CH_H      = 8'h48;
   localparam logic [7:0]  CH_ZERO   = 8'h30;
   localparam logic [7:0]  CH_NINE   = 8'h39;

   localparam int          BLOCK_WORDS = 10;
   localparam logic [3:0]  BLOCK_LIM   = 4'(BLOCK_WORDS);
   localparam logic [3:0]  PD_LAST     = 4'(BLOCK_WORDS - 1);

   localparam logic [1:0]  MODE_CLEAR = 2'd0;
   localparam logic [1:0]  MODE_LOAD  = 2'd1;
   localparam logic [1:0]  MODE_EXEC  = 2'd2;
   localparam logic [1:0]  MODE_DATA  = 2'd3;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_READ     = 3'd1,
      ST_WRITE    = 3'd2,
      ST_HALT     = 3'd3,
      ST_BAD_OP   = 3'd4,
      ST_BAD_OPND = 3'd5,
      ST_IGNORED  = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      K_CLEAR,
      K_LOAD,
      K_EXEC,
      K_DATA
   } kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_DECODE,
      S_MEM,
      S_PD,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [6:0]  address;
      logic [31:0] word;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] out_word;
      logic        out_last;
      logic        toggle;
   } rsp_type;

   typedef struct packed {
      kind_type    kind;
      logic        in_range;
      logic [6:0]  address;
      logic [31:0] word;
      logic        last;
   } item_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage

FILE: hw/rtl/cmeu_ram.sv
module cmeu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/cmeu_front.sv
module cmeu_front
   import cmeu_pkg::*;
#(
   parameter int STORE_WORDS = 100
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_push,
   output logic     req_full,
   input  req_type  req_data,
   output logic     item_valid,
   output item_type item,
   input  logic     item_pop
);

   localparam logic [6:0] STORE_LIM = 7'(STORE_WORDS);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   classified;
   logic       push_ok;
   logic       pop_ok;

   always_comb begin
      classified.address  = req_data.address;
      classified.word     = req_data.word;
      classified.last     = req_data.last;
      classified.in_range = req_data.address < STORE_LIM;
      unique case (req_data.mode)
         MODE_CLEAR: classified.kind = K_CLEAR;
         MODE_LOAD:  classified.kind = K_LOAD;
         MODE_EXEC:  classified.kind = K_EXEC;
         default:    classified.kind = K_DATA;
      endcase
   end

   assign req_full   = count_ff == 2'd2;
   assign item_valid = count_ff != 2'd0;
   assign item       = slot_ff[rd_ptr_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ pop_ok;
      count_in  = count_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

FILE: hw/rtl/cmeu_back.sv
`include "card_machine_execute_unit_top_assert.svh"

module cmeu_back
   import cmeu_pkg::*;
#(
   parameter int STORE_WORDS = 100
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     item_valid,
   input  item_type item,
   output logic     item_pop,
   output logic     rsp_empty,
   output rsp_type  rsp_data,
   input  logic     rsp_pop
);

   localparam int         AW        = $clog2(STORE_WORDS);
   localparam logic [6:0] STORE_LIM = 7'(STORE_WORDS);

   state_type              state_ff, state_in;
   logic [31:0]            gr_ff, gr_in;
   logic [31:0]            ir_ff, ir_in;
   logic [6:0]             ic_ff, ic_in;
   logic                   tog_ff, tog_in;
   logic                   stop_ff, stop_in;
   logic                   ract_ff, ract_in;
   logic [6:0]             rptr_ff, rptr_in;
   logic [3:0]             rcnt_ff, rcnt_in;
   status_type             status_ff, status_in;
   logic [6:0]             base_ff, base_in;
   logic [3:0]             pdi_ff, pdi_in;
   logic [STORE_WORDS-1:0] valid_ff, valid_in;
   logic                   vrd_ff, vrd_in;
   rsp_type                out_ff, out_in;
   logic                   outv_ff, outv_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [31:0]            wr_data;
   logic                   rd_issue;
   logic [6:0]             rd_addr7;
   logic                   rd_inr;
   logic [31:0]            ram_q;
   logic [31:0]            rd_word;
   logic                   out_free;
   logic [7:0]             c0, c1, c2, c3;
   logic [3:0]             tens, units;
   logic [6:0]             base7, op7;
   logic                   opc_ok;
   logic [3:0]             rcnt_next;

   cmeu_ram #(.WIDTH(32), .DEPTH(STORE_WORDS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_issue && rd_inr),
      .rd_addr (rd_addr7[AW-1:0]),
      .rd_data (ram_q)
   );

   assign rd_inr    = rd_addr7 < STORE_LIM;
   assign rd_word   = vrd_ff ? ram_q : SPACES;
   assign out_free  = !outv_ff || rsp_pop;
   assign rsp_empty = !outv_ff;
   assign rsp_data  = out_ff;

   assign c0    = ir_ff[31:24];
   assign c1    = ir_ff[23:16];
   assign c2    = ir_ff[15:8];
   assign c3    = ir_ff[7:0];
   assign tens  = c2[3:0];
   assign units = c3[3:0];
   assign base7 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
   assign op7   = base7 + 7'(units);
   assign rcnt_next = rcnt_ff + 4'd1;

   always_comb begin
      opc_ok = (c0 == CH_H)
            || (c0 == CH_G && c1 == CH_D) || (c0 == CH_P && c1 == CH_D)
            || (c0 == CH_L && c1 == CH_R) || (c0 == CH_S && c1 == CH_R)
            || (c0 == CH_C && c1 == CH_R) || (c0 == CH_B && c1 == CH_T);
   end

   always_comb begin
      state_in  = state_ff;
      gr_in     = gr_ff;
      ir_in     = ir_ff;
      ic_in     = ic_ff;
      tog_in    = tog_ff;
      stop_in   = stop_ff;
      ract_in   = ract_ff;
      rptr_in   = rptr_ff;
      rcnt_in   = rcnt_ff;
      status_in = status_ff;
      base_in   = base_ff;
      pdi_in    = pdi_ff;
      valid_in  = valid_ff;
      out_in    = out_ff;
      outv_in   = outv_ff && !rsp_pop;
      item_pop  = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = gr_ff;
      rd_issue  = 1'b0;
      rd_addr7  = ic_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_pop  = 1'b1;
               state_in  = S_RESP;
               status_in = ST_OK;
               unique case (item.kind)
                  K_CLEAR: begin
                     valid_in = '0;
                     ic_in    = '0;
                     tog_in   = 1'b0;
                     stop_in  = 1'b0;
                     ract_in  = 1'b0;
                     rptr_in  = '0;
                     rcnt_in  = '0;
                     ir_in    = {ir_ff[31:8], CH_SPACE};
                     gr_in    = {gr_ff[31:8], CH_SPACE};
                  end
                  K_LOAD: begin
                     if (item.in_range) begin
                        wr_en    = 1'b1;
                        wr_addr  = item.address[AW-1:0];
                        wr_data  = item.word;
                        valid_in[item.address[AW-1:0]] = 1'b1;
                     end else begin
                        status_in = ST_IGNORED;
                     end
                  end
                  K_DATA: begin
                     if (!ract_ff) begin
                        status_in = ST_IGNORED;
                     end else begin
                        if (rptr_ff < STORE_LIM) begin
                           wr_en   = 1'b1;
                           wr_addr = rptr_ff[AW-1:0];
                           wr_data = item.word;
                           valid_in[rptr_ff[AW-1:0]] = 1'b1;
                        end
                        rptr_in = rptr_ff + 7'd1;
                        rcnt_in = rcnt_next;
                        if (item.word == END_MARK || item.last || rcnt_next >= BLOCK_LIM) begin
                           ract_in = 1'b0;
                        end
                     end
                  end
                  default: begin
                     if (stop_ff || ract_ff) begin
                        status_in = ST_IGNORED;
                     end else if (ic_ff >= STORE_LIM) begin
                        stop_in   = 1'b1;
                        status_in = ST_BAD_OPND;
                     end else begin
                        rd_issue = 1'b1;
                        rd_addr7 = ic_ff;
                        state_in = S_FETCH;
                     end
                  end
               endcase
            end
         end
         S_FETCH: begin
            ir_in    = rd_word;
            ic_in    = ic_ff + 7'd1;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            state_in  = S_RESP;
            status_in = ST_OK;
            priority if (!opc_ok) begin
               stop_in   = 1'b1;
               status_in = ST_BAD_OP;
            end else if (c0 == CH_H) begin
               stop_in   = 1'b1;
               status_in = ST_HALT;
            end else if (!is_digit(c2) || !is_digit(c3) || op7 >= STORE_LIM) begin
               stop_in   = 1'b1;
               status_in = ST_BAD_OPND;
            end else if (c0 == CH_G) begin
               ract_in   = 1'b1;
               rptr_in   = base7;
               rcnt_in   = '0;
               status_in = ST_READ;
            end else if (c0 == CH_P) begin
               base_in  = base7;
               pdi_in   = '0;
               rd_issue = 1'b1;
               rd_addr7 = base7;
               state_in = S_PD;
            end else if (c0 == CH_L || c0 == CH_C) begin
               rd_issue = 1'b1;
               rd_addr7 = op7;
               state_in = S_MEM;
            end else if (c0 == CH_S) begin
               wr_en   = 1'b1;
               wr_addr = op7[AW-1:0];
               wr_data = gr_ff;
               valid_in[op7[AW-1:0]] = 1'b1;
            end else begin
               if (tog_ff) begin
                  ic_in  = op7;
                  tog_in = 1'b0;
               end
            end
         end
         S_MEM: begin
            if (c0 == CH_L) begin
               gr_in = rd_word;
            end else begin
               tog_in = rd_word == gr_ff;
            end
            state_in = S_RESP;
         end
         S_PD: begin
            if (out_free) begin
               outv_in         = 1'b1;
               out_in.status   = ST_WRITE;
               out_in.out_word = rd_word;
               out_in.out_last = pdi_ff == PD_LAST;
               out_in.toggle   = tog_ff;
               if (pdi_ff == PD_LAST) begin
                  state_in = S_IDLE;
               end else begin
                  // advance to the next word of the block
                  pdi_in   = pdi_ff + 4'd1;
                  rd_issue = 1'b1;
                  rd_addr7 = base_ff + 7'(pdi_ff) + 7'd1;
               end
            end
         end
         default: begin
            if (out_free) begin
               outv_in         = 1'b1;
               out_in.status   = status_ff;
               out_in.out_word = '0;
               out_in.out_last = 1'b0;
               out_in.toggle   = tog_ff;
               state_in        = S_IDLE;
            end
         end
      endcase

      vrd_in = rd_issue ? (rd_inr && valid_ff[rd_addr7[AW-1:0]]) : vrd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         gr_ff    <= '0;
         ir_ff    <= '0;
         ic_ff    <= '0;
         tog_ff   <= 1'b0;
         stop_ff  <= 1'b0;
         ract_ff  <= 1'b0;
         rptr_ff  <= '0;
         rcnt_ff  <= '0;
         valid_ff <= '0;
         outv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         gr_ff    <= gr_in;
         ir_ff    <= ir_in;
         ic_ff    <= ic_in;
         tog_ff   <= tog_in;
         stop_ff  <= stop_in;
         ract_ff  <= ract_in;
         rptr_ff  <= rptr_in;
         rcnt_ff  <= rcnt_in;
         valid_ff <= valid_in;
         outv_ff  <= outv_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      base_ff   <= base_in;
      pdi_ff    <= pdi_in;
      vrd_ff    <= vrd_in;
      out_ff    <= out_in;
   end

   `CMEU_ASSERT(a_pd_ends, clock, reset, (state_ff == S_PD && out_free && pdi_ff == PD_LAST) |=> (state_ff == S_IDLE))
   `CMEU_ASSERT(a_read_from_gd, clock, reset, $rose(ract_ff) |-> ($past(state_ff) == S_DECODE))
   `CMEU_ASSERT(a_out_held, clock, reset, (outv_ff && !rsp_pop) |=> outv_ff)
   `CMEU_ASSERT_ALWAYS(a_stopped_no_fetch, clock, (!reset && state_ff == S_IDLE && stop_ff && item_valid && item.kind == K_EXEC) |=> (state_ff == S_RESP))

endmodule

FILE: hw/rtl/card_machine_execute_unit_top.sv
// Teaching machine with a 100-word store of four-character words. Each beat
// pushed on req_ clears the job, loads a program word, runs one instruction or
// delivers a GD data word; results are popped from rsp_ in order. A front
// queue of two beats takes items while the sequencer works. An instruction passes
// through fetch and decode, then a store read for LR/CR, before its response; PD
// emits its block words as rsp_ has room. The word store has a single registered
// read port. Clear resets every per-word valid flag in the same cycle.
module card_machine_execute_unit_top
   import cmeu_pkg::*;
#(
   parameter int STORE_WORDS = 100
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   item_type item;
   logic     item_valid;
   logic     item_pop;

   cmeu_front #(.STORE_WORDS(STORE_WORDS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   cmeu_back #(.STORE_WORDS(STORE_WORDS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_empty  (rsp_empty),
      .rsp_data   (rsp_data),
      .rsp_pop    (rsp_pop)
   );

endmodule
